// ===== src/lla_pkg.sv =====
// shared types and constants of the life-like automaton step block
package lla_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int COL_W = $clog2(GRID_WIDTH);
  localparam int ROW_W = $clog2(GRID_HEIGHT);
  localparam int CNT_W = $clog2(GRID_HEIGHT + 1);

  typedef logic [GRID_WIDTH-1:0] row_t;

  localparam row_t ROW_ONES = '1;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

  localparam logic [1:0] REG_SURVIVE_MIN = 2'd0;
  localparam logic [1:0] REG_SURVIVE_MAX = 2'd1;
  localparam logic [1:0] REG_BIRTH_MIN   = 2'd2;
  localparam logic [1:0] REG_BIRTH_MAX   = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] col;
    logic [5:0] row;
    logic       cell_value;
  } in_item_t;

  typedef struct packed {
    logic read_value;
    logic done_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_DAT,
    ST_GEN,
    ST_GEN_TAIL,
    ST_RESP
  } state_t;

endpackage

// ===== src/life_like_automaton_step.sv =====
// top level of the life-like automaton step block: grid memory, cell access and generation sweep
//
// usage
//   in channel (in_valid/in_ready, in_data): one command beat per item; mode selects
//   write one cell, read one cell or run one generation over the whole grid
//   out channel (out_valid/out_ready, out_data): one result beat per command, with
//   read_value and done_res; an unused mode gives done_res 0 and changes nothing
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes the survive and
//   birth ranges; always ready, meant to be written while the block is idle
// timing
//   cell write or read: a row read, then modify/write back, before the result beat
//   generation: one sweep over all GRID_HEIGHT rows through the single read port of the
//   grid memory, which delivers one full row per cycle
//   commands are taken one at a time; in_ready is high only while idle
// reset
//   all rows carry a valid bit cleared by reset, so the grid reads as all dead at once
//   with no clearing pass; ranges return to survive 4..8, birth 5..5
// stall
//   the result sits in an output register; the next command is accepted while it waits,
//   and that command's own result holds in the response state until the register frees
module life_like_automaton_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lla_pkg::in_item_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lla_pkg::out_item_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [3:0]       cfg_data
);
  import lla_pkg::*;

  // control state
  state_t             st_r, st_nxt;
  in_item_t           in_r;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               ret_vld_r;
  logic [ROW_W-1:0]   ret_row_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic               res_rd_r, res_done_r;

  // configuration
  logic [3:0]         surv_min_r, surv_max_r, birth_min_r, birth_max_r;

  // grid memory, one row per entry, plus per-row valid bits
  row_t               mem [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] row_vld_r;
  row_t               rdata_r;
  logic               rvld_r;
  row_t               rd_row;

  // row window of the sweep: a copy of the previous row and the row being evaluated
  row_t               prev_r, here_r;
  row_t               gen_row;

  // memory port controls
  logic               mem_re, mem_we;
  logic [ROW_W-1:0]   mem_raddr, mem_waddr;
  row_t               mem_wdata;

  logic               accept, out_free;
  logic               in_grid;
  logic [ROW_W-1:0]   row_idx;
  logic [COL_W-1:0]   col_idx;
  logic               issue_rd;
  logic               last_ret;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // coordinate decode of the held command
  assign in_grid = (int'(in_r.col) < GRID_WIDTH) && (int'(in_r.row) < GRID_HEIGHT);
  assign row_idx = ROW_W'(in_r.row);
  assign col_idx = COL_W'(in_r.col);

  // rows never written since reset read as all dead
  assign rd_row = rvld_r ? rdata_r : '0;

  assign issue_rd = (st_r == ST_GEN) && (int'(rd_cnt_r) < GRID_HEIGHT);
  assign last_ret = ret_vld_r && (ret_row_r == ROW_W'(GRID_HEIGHT - 1));

  // next generation of the row in here_r, from the original rows above and below
  always_comb begin
    logic [3:0] n;
    logic       live;
    gen_row = '0;
    for (int c = 1; c < GRID_WIDTH - 1; c++) begin
      n = 4'(prev_r[c-1]) + 4'(prev_r[c]) + 4'(prev_r[c+1])
        + 4'(here_r[c-1]) + 4'(here_r[c+1])
        + 4'(rd_row[c-1]) + 4'(rd_row[c]) + 4'(rd_row[c+1]);
      if (here_r[c]) begin
        live = (n >= surv_min_r) && (n <= surv_max_r);
      end else begin
        live = (n >= birth_min_r) && (n <= birth_max_r);
      end
      gen_row[c] = live;
    end
    // border columns always end alive
    gen_row[0]            = 1'b1;
    gen_row[GRID_WIDTH-1] = 1'b1;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.mode)
            MODE_WRITE: st_nxt = ST_CELL_RD;
            MODE_READ:  st_nxt = ST_CELL_RD;
            MODE_RUN:   st_nxt = ST_GEN;
            default:    st_nxt = ST_RESP;
          endcase
        end
      end
      ST_CELL_RD:  st_nxt = ST_CELL_DAT;
      ST_CELL_DAT: st_nxt = ST_RESP;
      ST_GEN: begin
        if (last_ret) begin
          st_nxt = ST_GEN_TAIL;
        end
      end
      ST_GEN_TAIL: st_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = row_idx;
    mem_we    = 1'b0;
    mem_waddr = row_idx;
    mem_wdata = rd_row;
    case (st_r)
      ST_CELL_RD: begin
        mem_re = in_grid;
      end
      ST_CELL_DAT: begin
        // read-modify-write of one cell
        if (in_r.mode == MODE_WRITE && in_grid) begin
          mem_we             = 1'b1;
          mem_wdata[col_idx] = in_r.cell_value;
        end
      end
      ST_GEN: begin
        mem_re    = issue_rd;
        mem_raddr = rd_cnt_r[ROW_W-1:0];
        if (ret_vld_r) begin
          if (ret_row_r == '0) begin
            // top border row
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = ROW_ONES;
          end else if (ret_row_r != ROW_W'(1)) begin
            // row above the one just returned has its full window now
            mem_we    = 1'b1;
            mem_waddr = ret_row_r - ROW_W'(1);
            mem_wdata = gen_row;
          end
        end
      end
      ST_GEN_TAIL: begin
        // bottom border row
        mem_we    = 1'b1;
        mem_waddr = ROW_W'(GRID_HEIGHT - 1);
        mem_wdata = ROW_ONES;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // grid memory, reads always run ahead of write-back, so no same-row overlap
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      if (mem_re) begin
        rvld_r <= row_vld_r[mem_raddr];
      end
      if (mem_we) begin
        row_vld_r[mem_waddr] <= 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      rd_cnt_r    <= '0;
      ret_vld_r   <= 1'b0;
      ret_row_r   <= '0;
      out_valid_r <= 1'b0;
      surv_min_r  <= 4'd4;
      surv_max_r  <= 4'd8;
      birth_min_r <= 4'd5;
      birth_max_r <= 4'd5;
    end else begin
      st_r      <= st_nxt;
      ret_vld_r <= issue_rd;
      // row number of the read now in flight
      if (issue_rd) begin
        ret_row_r <= rd_cnt_r[ROW_W-1:0];
      end
      if (accept) begin
        rd_cnt_r <= '0;
      end else if (issue_rd) begin
        rd_cnt_r <= rd_cnt_r + CNT_W'(1);
      end
      if (st_r == ST_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SURVIVE_MIN: surv_min_r  <= cfg_data;
          REG_SURVIVE_MAX: surv_max_r  <= cfg_data;
          REG_BIRTH_MIN:   birth_min_r <= cfg_data;
          REG_BIRTH_MAX:   birth_max_r <= cfg_data;
          default:         surv_min_r  <= surv_min_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r       <= in_data;
      prev_r     <= '0;
      res_rd_r   <= 1'b0;
      res_done_r <= (in_data.mode == MODE_WRITE) || (in_data.mode == MODE_READ)
                 || (in_data.mode == MODE_RUN);
    end
    if (st_r == ST_GEN && ret_vld_r) begin
      prev_r <= here_r;
      here_r <= rd_row;
    end
    if (st_r == ST_CELL_DAT) begin
      res_rd_r <= (in_r.mode == MODE_READ) && in_grid && rd_row[col_idx];
    end
    if (st_r == ST_RESP && out_free) begin
      out_data_r.read_value <= res_rd_r;
      out_data_r.done_res   <= res_done_r;
    end
  end

endmodule
